// ===== src/mtgp_pkg.sv =====
package mtgp_pkg;

    // Glyph map is fixed at one entry per byte value
    localparam int MAP_ENTRIES         = 256;
    localparam int STACK_DEPTH_DEFAULT = 16;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_OVERLAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_STYLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVELS = 3'd4;

    localparam logic [7:0] GLYPH_WIDTH_RST  = 8'd8;
    localparam logic [7:0] GLYPH_HEIGHT_RST = 8'd8;
    localparam logic [7:0] CHAR_OVERLAP_RST = 8'd0;
    localparam logic [8:0] COLOR_STYLES_RST = 9'd1;
    localparam logic [3:0] ALPHA_LEVELS_RST = 4'd2;

    // Markup characters
    localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
    localparam logic [7:0] CH_POP   = 8'h3C;  // '<'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_QUOTE = 8'h27;  // single quote
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // Action codes
    localparam logic ACT_MAP_WRITE = 1'b0;
    localparam logic ACT_TEXT      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_WB,
        ST_DIV,
        ST_PUSH,
        ST_MAP_RD,
        ST_MUL_X,
        ST_MUL_Y,
        ST_OUT
    } state_t;

endpackage

// ===== src/markup_text_glyph_placer_unit.sv =====
// Channel   | Ports                                            | Direction
// ----------+--------------------------------------------------+----------
// input     | s_valid/s_ready, s_action, s_text_byte,          | in
//           | s_map_slot, s_string_start, s_start_x, s_start_y |
// result    | m_valid/m_ready, m_sheet_x, m_sheet_y,           | out
//           | m_alpha_index, m_dest_x, m_dest_y,               |
//           | m_stack_overflow                                 |
// config    | cfg_valid/cfg_ready, cfg_index, cfg_data         | in
//
// Map write, lone '^' and no-op bytes stay in the idle state; a pop may read
// the stack; a push runs 8 steps of the shared bit-serial remainder unit; a
// printed glyph does a map read, then two passes through one 8x8 multiplier.
// Reset (aresetn low, synchronous) clears the sequencer, stack count, pen,
// attributes, overflow flag, map valid bits and config registers.
// A stalled result holds in the output register; the sequencer then waits
// in its output state and s_ready stays low until the register frees up.
// cfg_ready is always high.
module markup_text_glyph_placer_unit #(
    parameter int STACK_DEPTH = mtgp_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [7:0]                      s_text_byte,
    input  logic [7:0]                      s_map_slot,
    input  logic                            s_string_start,
    input  logic signed [15:0]              s_start_x,
    input  logic signed [15:0]              s_start_y,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_sheet_x,
    output logic [15:0]                     m_sheet_y,
    output logic [2:0]                      m_alpha_index,
    output logic signed [15:0]              m_dest_x,
    output logic signed [15:0]              m_dest_y,
    output logic                            m_stack_overflow,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mtgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtgp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtgp_pkg::*;

    // Stack address and count widths
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [7:0] glyph_width_reg;
    logic [7:0] glyph_height_reg;
    logic [7:0] char_overlap_reg;
    logic [8:0] color_styles_reg;
    logic [3:0] alpha_levels_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg  <= GLYPH_WIDTH_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
            char_overlap_reg <= CHAR_OVERLAP_RST;
            color_styles_reg <= COLOR_STYLES_RST;
            alpha_levels_reg <= ALPHA_LEVELS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[7:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[7:0];
                CFG_CHAR_OVERLAP: char_overlap_reg <= cfg_data[7:0];
                CFG_COLOR_STYLES: color_styles_reg <= cfg_data;
                CFG_ALPHA_LEVELS: alpha_levels_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // A zero count register behaves as one
    logic [8:0] styles_eff;
    logic [8:0] levels_eff;
    assign styles_eff = (color_styles_reg == 9'd0) ? 9'd1 : color_styles_reg;
    assign levels_eff = (alpha_levels_reg == 4'd0) ? 9'd1 : {5'd0, alpha_levels_reg};

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t         state_reg, state_next;
    logic [7:0]     byte_reg, byte_next;
    logic           kind_reg, kind_next;         // 1: alpha push, 0: color push
    logic [CW-1:0]  count_reg, count_next;
    logic           esc_reg, esc_next;
    logic [7:0]     color_reg, color_next;
    logic [2:0]     alpha_reg, alpha_next;
    logic [15:0]    pen_x_reg, pen_x_next;
    logic [15:0]    pen_y_reg, pen_y_next;
    logic           ovf_reg, ovf_next;

    // Shared remainder unit: restoring, one dividend bit per cycle
    logic [8:0]     rem_reg, rem_next;
    logic [7:0]     dvd_reg, dvd_next;
    logic [8:0]     dvs_reg, dvs_next;
    logic [2:0]     step_reg, step_next;
    logic [8:0]     rem_trial;

    // Shared 8x8 multiplier
    logic [7:0]     mul_a, mul_b;
    logic [15:0]    mul_p;
    logic [15:0]    sheet_x_reg, sheet_x_next;

    // Output register
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    m_sheet_x_reg, m_sheet_x_next;
    logic [15:0]    m_sheet_y_reg, m_sheet_y_next;
    logic [2:0]     m_alpha_reg, m_alpha_next;
    logic [15:0]    m_dest_x_reg, m_dest_x_next;
    logic [15:0]    m_dest_y_reg, m_dest_y_next;
    logic           m_ovf_reg, m_ovf_next;
    logic [15:0]    sheet_y_reg, sheet_y_next;

    // Memories
    logic [7:0]     map_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] map_valid_reg;
    logic [7:0]     map_rd_reg;
    logic           map_rd_valid_reg;
    logic           map_we;

    // Each stack entry holds the color and alpha in force once it is on top
    logic [10:0]    stk_mem [STACK_DEPTH];
    logic [10:0]    stk_rd_reg;
    logic           stk_we;
    logic [10:0]    stk_wdata;

    logic           accept;
    logic           esc_eff;
    logic           out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign esc_eff  = esc_reg && !s_string_start;

    assign rem_trial = {rem_reg[7:0], dvd_reg[7]};
    assign mul_p     = {8'd0, mul_a} * {8'd0, mul_b};

    // Glyph map: valid bits stand in for the reset clear
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[s_text_byte] <= s_map_slot;
        end
        if (state_reg == ST_MAP_RD) begin
            map_rd_reg       <= map_mem[byte_reg];
            map_rd_valid_reg <= map_valid_reg[byte_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= '0;
        end else if (map_we) begin
            map_valid_reg[s_text_byte] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[count_reg[SW-1:0]] <= stk_wdata;
        end
        if (state_reg == ST_POP_RD) begin
            stk_rd_reg <= stk_mem[SW'(count_reg - CW'(1))];
        end
    end

    // ---------------------------------------------------------------
    // Next state and datapath control
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        esc_next       = esc_reg;
        color_next     = color_reg;
        alpha_next     = alpha_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        sheet_x_next   = sheet_x_reg;
        sheet_y_next   = sheet_y_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sheet_x_next = m_sheet_x_reg;
        m_sheet_y_next = m_sheet_y_reg;
        m_alpha_next   = m_alpha_reg;
        m_dest_x_next  = m_dest_x_reg;
        m_dest_y_next  = m_dest_y_reg;
        m_ovf_next     = m_ovf_reg;
        mul_a          = map_rd_valid_reg ? map_rd_reg : 8'd0;
        mul_b          = glyph_width_reg;
        map_we         = 1'b0;
        stk_we         = 1'b0;
        stk_wdata      = {color_reg, alpha_reg};

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next = s_text_byte;
                    if (s_action == ACT_MAP_WRITE) begin
                        map_we = 1'b1;
                    end else begin
                        if (s_string_start) begin
                            count_next = '0;
                            esc_next   = 1'b0;
                            color_next = 8'd0;
                            alpha_next = 3'd0;
                            pen_x_next = s_start_x;
                            pen_y_next = s_start_y;
                        end
                        if (esc_eff) begin
                            esc_next = 1'b0;
                            if (s_text_byte == CH_POP) begin
                                // Pop; an empty stack leaves color and alpha at zero
                                if (count_reg != '0) begin
                                    count_next = count_reg - CW'(1);
                                    if (count_reg == CW'(1)) begin
                                        color_next = 8'd0;
                                        alpha_next = 3'd0;
                                    end else begin
                                        state_next = ST_POP_RD;
                                    end
                                end
                            end else if (s_text_byte >= CH_HASH
                                         && s_text_byte <= CH_QUOTE) begin
                                kind_next  = 1'b1;
                                rem_next   = '0;
                                dvd_next   = s_text_byte - CH_HASH;
                                dvs_next   = levels_eff;
                                step_next  = '0;
                                state_next = ST_DIV;
                            end else if (s_text_byte != CH_CARET) begin
                                kind_next  = 1'b0;
                                rem_next   = '0;
                                dvd_next   = (s_text_byte >= CH_ZERO)
                                             ? s_text_byte - CH_ZERO
                                             : CH_ZERO - s_text_byte;
                                dvs_next   = styles_eff;
                                step_next  = '0;
                                state_next = ST_DIV;
                            end else begin
                                state_next = ST_MAP_RD;   // quoted caret prints
                            end
                        end else if (s_text_byte == CH_CARET) begin
                            esc_next = 1'b1;
                        end else begin
                            state_next = ST_MAP_RD;
                        end
                    end
                end
            end

            ST_POP_RD: begin
                state_next = ST_POP_WB;
            end

            ST_POP_WB: begin
                color_next = stk_rd_reg[10:3];
                alpha_next = stk_rd_reg[2:0];
                state_next = ST_IDLE;
            end

            ST_DIV: begin
                rem_next  = (rem_trial >= dvs_reg) ? rem_trial - dvs_reg : rem_trial;
                dvd_next  = {dvd_reg[6:0], 1'b0};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH: begin
                if (count_reg == CW'(STACK_DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    if (kind_reg) begin
                        alpha_next = rem_reg[2:0];
                        stk_wdata  = {color_reg, rem_reg[2:0]};
                    end else begin
                        color_next = rem_reg[7:0];
                        stk_wdata  = {rem_reg[7:0], alpha_reg};
                    end
                    stk_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end

            ST_MAP_RD: begin
                state_next = ST_MUL_X;
            end

            ST_MUL_X: begin
                sheet_x_next = mul_p;
                state_next   = ST_MUL_Y;
            end

            ST_MUL_Y: begin
                mul_a        = color_reg;
                mul_b        = glyph_height_reg;
                sheet_y_next = mul_p;
                state_next   = ST_OUT;
            end

            ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_sheet_x_next = sheet_x_reg;
                    m_sheet_y_next = sheet_y_reg;
                    m_alpha_next   = alpha_reg;
                    m_dest_x_next  = pen_x_reg;
                    m_dest_y_next  = pen_y_reg;
                    m_ovf_next     = ovf_reg;
                    // Advance may be negative; wraps at 16 bits
                    pen_x_next = pen_x_reg + {8'd0, glyph_width_reg}
                                 - {8'd0, char_overlap_reg};
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            esc_reg     <= 1'b0;
            color_reg   <= 8'd0;
            alpha_reg   <= 3'd0;
            pen_x_reg   <= 16'd0;
            pen_y_reg   <= 16'd0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            esc_reg     <= esc_next;
            color_reg   <= color_next;
            alpha_reg   <= alpha_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        kind_reg      <= kind_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        step_reg      <= step_next;
        sheet_x_reg   <= sheet_x_next;
        sheet_y_reg   <= sheet_y_next;
        m_sheet_x_reg <= m_sheet_x_next;
        m_sheet_y_reg <= m_sheet_y_next;
        m_alpha_reg   <= m_alpha_next;
        m_dest_x_reg  <= m_dest_x_next;
        m_dest_y_reg  <= m_dest_y_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_sheet_x        = m_sheet_x_reg;
    assign m_sheet_y        = m_sheet_y_reg;
    assign m_alpha_index    = m_alpha_reg;
    assign m_dest_x         = m_dest_x_reg;
    assign m_dest_y         = m_dest_y_reg;
    assign m_stack_overflow = m_ovf_reg;

endmodule

// ===== tb/tb_markup_text_glyph_placer_unit.sv =====
`timescale 1ns / 1ps

module tb_markup_text_glyph_placer_unit;
    import mtgp_pkg::*;

    localparam int STACK_DEPTH  = STACK_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE_WAIT  = 24;    // covers a push with margin

    // One input transaction, one field per port
    typedef struct {
        logic              action;
        logic [7:0]        text_byte;
        logic [7:0]        map_slot;
        logic              string_start;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } text_item_t;

    // One glyph placement on the result channel
    typedef struct {
        logic [15:0]        sheet_x;
        logic [15:0]        sheet_y;
        logic [2:0]         alpha_index;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic               stack_overflow;
    } glyph_t;

    // Directed row: stimulus plus an optional hand-written placement
    typedef struct {
        text_item_t it;
        bit         typed;
        glyph_t     g;
    } directed_row_t;

    // ---------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ---------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_action       = 1'b0;
    logic [7:0]         s_text_byte    = '0;
    logic [7:0]         s_map_slot     = '0;
    logic               s_string_start = 1'b0;
    logic signed [15:0] s_start_x      = '0;
    logic signed [15:0] s_start_y      = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_sheet_x;
    logic [15:0]        m_sheet_y;
    logic [2:0]         m_alpha_index;
    logic signed [15:0] m_dest_x;
    logic signed [15:0] m_dest_y;
    logic               m_stack_overflow;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    markup_text_glyph_placer_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_text_byte      (s_text_byte),
        .s_map_slot       (s_map_slot),
        .s_string_start   (s_string_start),
        .s_start_x        (s_start_x),
        .s_start_y        (s_start_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sheet_x        (m_sheet_x),
        .m_sheet_y        (m_sheet_y),
        .m_alpha_index    (m_alpha_index),
        .m_dest_x         (m_dest_x),
        .m_dest_y         (m_dest_y),
        .m_stack_overflow (m_stack_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Shadow state of the placer
    // ---------------------------------------------------------------------
    logic [7:0]  glyph_map [MAP_ENTRIES];
    bit          stk_alpha [STACK_DEPTH];   // entry kind: 1 = alpha, 0 = color
    logic [7:0]  stk_val   [STACK_DEPTH];
    int          depth     = 0;
    bit          esc_armed = 1'b0;
    logic [7:0]  cur_color = '0;
    logic [2:0]  cur_alpha = '0;
    logic [15:0] pen_x     = '0;
    logic [15:0] pen_y     = '0;
    bit          ovf_flag  = 1'b0;

    // Shadow config, starts at reset values
    logic [7:0] cell_w   = GLYPH_WIDTH_RST;
    logic [7:0] cell_h   = GLYPH_HEIGHT_RST;
    logic [7:0] overlap  = CHAR_OVERLAP_RST;
    logic [8:0] n_styles = COLOR_STYLES_RST;
    logic [3:0] n_levels = ALPHA_LEVELS_RST;

    glyph_t        expected_glyphs[$];
    directed_row_t directed_rows[$];

    // Run bookkeeping
    int errors       = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_map_writes = 0;
    int n_pushes     = 0;
    int n_dropped    = 0;
    int n_settings   = 0;
    int cycle_count  = 0;

    // Sender burst control
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    // Receiver stall control
    int hold_ask    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int ready_mode  = 0;
    int ready_run   = 0;

    function automatic glyph_t glyph(input logic [15:0] sx, input logic [15:0] sy,
                                     input logic [2:0] a, input logic signed [15:0] dx,
                                     input logic signed [15:0] dy, input logic ovf);
        glyph_t g;
        g.sheet_x        = sx;
        g.sheet_y        = sy;
        g.alpha_index    = a;
        g.dest_x         = dx;
        g.dest_y         = dy;
        g.stack_overflow = ovf;
        return g;
    endfunction

    function automatic text_item_t mk(input logic act, input logic [7:0] b,
                                      input logic [7:0] slot, input logic start,
                                      input logic signed [15:0] sx,
                                      input logic signed [15:0] sy);
        text_item_t it;
        it.action       = act;
        it.text_byte    = b;
        it.map_slot     = slot;
        it.string_start = start;
        it.start_x      = sx;
        it.start_y      = sy;
        return it;
    endfunction

    // Ignored fields get random content too, so every port bit toggles
    function automatic text_item_t rand_item(input logic act, input logic [7:0] b,
                                             input logic start);
        return mk(act, b, 8'($urandom_range(0, 255)), start,
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    function automatic void add_row(input text_item_t it, input bit typed, input glyph_t g);
        directed_row_t r;
        r.it    = it;
        r.typed = typed;
        r.g     = g;
        directed_rows.push_back(r);
    endfunction

    // Topmost entry of each kind wins; none of a kind means 0
    function automatic void refresh_attrs();
        bit got_c, got_a;
        got_c     = 1'b0;
        got_a     = 1'b0;
        cur_color = '0;
        cur_alpha = '0;
        for (int i = depth - 1; i >= 0; i--) begin
            if (stk_alpha[i]) begin
                if (!got_a) begin
                    cur_alpha = stk_val[i][2:0];
                    got_a     = 1'b1;
                end
            end else if (!got_c) begin
                cur_color = stk_val[i];
                got_c     = 1'b1;
            end
        end
    endfunction

    function automatic void push_attr(input bit is_alpha, input logic [7:0] v);
        n_pushes++;
        if (depth >= STACK_DEPTH) begin
            ovf_flag = 1'b1;     // sticky, survives string start
            n_dropped++;
        end else begin
            stk_alpha[depth] = is_alpha;
            stk_val[depth]   = v;
            depth++;
        end
        refresh_attrs();
    endfunction

    // Advances the shadow state by one transaction; 1 when a glyph is placed
    function automatic bit place_glyph(input text_item_t it, output glyph_t g);
        logic [3:0] lv;
        logic [8:0] st;
        logic [8:0] val;
        logic [7:0] mag;
        g = glyph(0, 0, 0, 0, 0, 1'b0);
        if (it.action == ACT_MAP_WRITE) begin
            glyph_map[it.text_byte] = it.map_slot;
            n_map_writes++;
            return 1'b0;
        end
        if (it.string_start) begin
            depth     = 0;
            esc_armed = 1'b0;
            cur_color = '0;
            cur_alpha = '0;
            pen_x     = it.start_x;
            pen_y     = it.start_y;
        end
        if (esc_armed) begin
            esc_armed = 1'b0;
            if (it.text_byte == CH_POP) begin
                if (depth > 0) depth--;
                refresh_attrs();
                return 1'b0;
            end
            if (it.text_byte >= CH_HASH && it.text_byte <= CH_QUOTE) begin
                lv  = (n_levels == 0) ? 4'd1 : n_levels;
                val = 9'(it.text_byte - CH_HASH) % 9'(lv);
                push_attr(1'b1, val[7:0]);
                return 1'b0;
            end
            if (it.text_byte != CH_CARET) begin
                st  = (n_styles == 0) ? 9'd1 : n_styles;
                mag = (it.text_byte >= CH_ZERO) ? it.text_byte - CH_ZERO
                                                : CH_ZERO - it.text_byte;
                val = 9'(mag) % st;
                push_attr(1'b0, val[7:0]);
                return 1'b0;
            end
            // quoted caret falls through and prints
        end else if (it.text_byte == CH_CARET) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        g.sheet_x        = 16'(glyph_map[it.text_byte]) * 16'(cell_w);
        g.sheet_y        = 16'(cur_color) * 16'(cell_h);
        g.alpha_index    = cur_alpha;
        g.dest_x         = pen_x;
        g.dest_y         = pen_y;
        g.stack_overflow = ovf_flag;
        pen_x            = pen_x + 16'(cell_w) - 16'(overlap);   // 16-bit wrap, may go backward
        return 1'b1;
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between
    // ---------------------------------------------------------------------
    task automatic offer(input text_item_t it, input bit typed, input glyph_t typed_g);
        glyph_t g;
        int     gap;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid        <= 1'b1;
        s_action       <= it.action;
        s_text_byte    <= it.text_byte;
        s_map_slot     <= it.map_slot;
        s_string_start <= it.string_start;
        s_start_x      <= it.start_x;
        s_start_y      <= it.start_y;
        do @(posedge aclk); while (s_ready !== 1'b1);
        n_accepted++;
        if (place_glyph(it, g))
            expected_glyphs.push_back(typed ? typed_g : g);
    endtask

    // Drop valid, wait for every expected glyph, then let a trailing push finish
    task automatic settle();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (expected_glyphs.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_GLYPH_WIDTH:  cell_w   = val[7:0];
            CFG_GLYPH_HEIGHT: cell_h   = val[7:0];
            CFG_CHAR_OVERLAP: overlap  = val[7:0];
            CFG_COLOR_STYLES: n_styles = val;
            CFG_ALPHA_LEVELS: n_levels = val[3:0];
            default: ;
        endcase
    endtask

    task automatic program_cfg(input int w, input int h, input int ov,
                               input int st, input int lv);
        write_reg(CFG_GLYPH_WIDTH,  CFG_DATA_W'(w));
        write_reg(CFG_GLYPH_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_CHAR_OVERLAP, CFG_DATA_W'(ov));
        write_reg(CFG_COLOR_STYLES, CFG_DATA_W'(st));
        write_reg(CFG_ALPHA_LEVELS, CFG_DATA_W'(lv));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Escape code byte: alpha push, pop, quoted caret or color push
    function automatic logic [7:0] esc_code(input bit allow_pop);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CH_HASH + 8'($urandom_range(0, 4));
        if (r < 55 && allow_pop) return CH_POP;
        if (r >= 55 && r < 60) return CH_CARET;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed markup with random content, some noise on top
    task automatic random_stretch(input int count);
        int         sent, pick, storm;
        logic [7:0] b;
        glyph_t     none;
        none = glyph(0, 0, 0, 0, 0, 1'b0);
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                offer(rand_item(ACT_MAP_WRITE, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))), 1'b0, none);
                sent++;
            end else if (pick < 18) begin
                // new string, first byte anything
                offer(rand_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b1), 1'b0, none);
                sent++;
            end else if (pick < 48) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_CARET) b = 8'h20;
                offer(rand_item(ACT_TEXT, b, 1'b0), 1'b0, none);
                sent++;
            end else if (pick < 80) begin
                offer(rand_item(ACT_TEXT, CH_CARET, 1'b0), 1'b0, none);
                offer(rand_item(ACT_TEXT, esc_code(1'b1), 1'b0), 1'b0, none);
                sent += 2;
            end else if (pick < 83) begin
                // push storm, can run the stack past full
                storm = $urandom_range(14, 20);
                repeat (storm) begin
                    offer(rand_item(ACT_TEXT, CH_CARET, 1'b0), 1'b0, none);
                    offer(rand_item(ACT_TEXT, esc_code(1'b0), 1'b0), 1'b0, none);
                end
                sent += 2 * storm;
            end else begin
                offer(rand_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                $urandom_range(0, 3) == 0), 1'b0, none);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver: own stall pattern, long hold-off on request, checks results
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        glyph_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_glyphs.size() == 0) begin
                    $display("%0t: glyph transaction with nothing expected, actual x=0x%h y=0x%h",
                             $time, m_dest_x, m_dest_y);
                    errors++;
                end else begin
                    want = expected_glyphs.pop_front();
                    cmp_field("sheet_x",        want.sheet_x,               m_sheet_x);
                    cmp_field("sheet_y",        want.sheet_y,               m_sheet_y);
                    cmp_field("alpha_index",    16'(want.alpha_index),      16'(m_alpha_index));
                    cmp_field("dest_x",         want.dest_x,                m_dest_x);
                    cmp_field("dest_y",         want.dest_y,                m_dest_y);
                    cmp_field("stack_overflow", 16'(want.stack_overflow),
                              16'(m_stack_overflow));
                    n_checked++;
                end
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (ready_run == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    ready_run  = $urandom_range(4, 64);
                end
                ready_run--;
                case (ready_mode)
                    0: m_ready <= 1'b1;                          // no stalls
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (ready_run % 3) == 0;          // mostly stalled
                    default: m_ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d glyph transactions still expected",
                     $time, expected_glyphs.size());
            $display("markup_text_glyph_placer_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        glyph_t none;
        none = glyph(0, 0, 0, 0, 0, 1'b0);
        for (int i = 0; i < MAP_ENTRIES; i++) glyph_map[i] = '0;

        // Directed rows, reset config: width 8, height 8, no overlap,
        // one color row, two alpha copies. The first map write carries
        // extreme junk in the ignored fields.
        add_row(mk(ACT_MAP_WRITE, 8'h41, 8'hFF, 1'b1, 16'sh7FFF, -16'sd1), 1'b0, none);
        add_row(mk(ACT_MAP_WRITE, 8'hFF, 8'h07, 1'b0, 0, 0), 1'b0, none);  // key 255
        // largest slot, pen at the positive extreme
        add_row(mk(ACT_TEXT, 8'h41, 8'h00, 1'b1, 16'sh7FFF, -16'sd32768), 1'b1,
                glyph(16'd2040, 0, 0, 16'sh7FFF, -16'sd32768, 1'b0));
        // pen wraps past +32767
        add_row(mk(ACT_TEXT, 8'hFF, 8'hFF, 1'b0, -16'sd1, -16'sd1), 1'b1,
                glyph(16'd56, 0, 0, -16'sd32761, -16'sd32768, 1'b0));
        // lone caret, then quoted caret prints
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b1,
                glyph(0, 0, 0, -16'sd32753, -16'sd32768, 1'b0));
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_HASH,  0, 1'b0, 0, 0), 1'b0, none);         // alpha 0
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h24,    0, 1'b0, 0, 0), 1'b0, none);         // alpha 1
        add_row(mk(ACT_TEXT, 8'h41,    0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_POP,   0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h35,    0, 1'b0, 0, 0), 1'b0, none);         // color '5'
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_QUOTE, 0, 1'b0, 0, 0), 1'b0, none);         // top alpha code
        // pending escape thrown away by a new string at the negative extreme
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h5A, 0, 1'b1, -16'sd32768, 16'sh7FFF), 1'b1,
                glyph(0, 0, 0, -16'sd32768, 16'sh7FFF, 1'b0));
        // pop with nothing stacked
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_POP,   0, 1'b0, 0, 0), 1'b0, none);
        // color codes below '0' and above 127
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h00,    0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, CH_CARET, 0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h80,    0, 1'b0, 0, 0), 1'b0, none);
        add_row(mk(ACT_TEXT, 8'h41,    0, 1'b0, 0, 0), 1'b0, none);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
            offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].g);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_cfg(255, 255, 0, 256, 8);       // maximum sizes and counts, no overlap
                1: program_cfg(1, 1, 255, 1, 1);           // minimums, pen walks backward
                2: program_cfg(200, 3, 200, 0, 0);         // zero counts act as one, no advance
                default: program_cfg($urandom_range(1, 255), $urandom_range(1, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 256),
                                     $urandom_range(0, 8));
            endcase
            if (ph == 3) begin
                // receiver holds off while the sender keeps pushing back to back
                random_stretch(60);
                hold_ask++;
                no_gaps = 1'b1;
                random_stretch(30);
                no_gaps = 1'b0;
                random_stretch(50);
            end else if (ph == 5) begin
                // sender stops until the result channel is empty
                random_stretch(70);
                settle();
                random_stretch(70);
            end else begin
                random_stretch(140);
            end
            settle();
        end

        $display("Covered %0d input transactions (%0d map writes, %0d stack pushes, %0d dropped)",
                 n_accepted, n_map_writes, n_pushes, n_dropped);
        $display("under %0d register settings; %0d glyph transactions compared, %0d mismatches.",
                 n_settings, n_checked, errors);
        if (expected_glyphs.size() != 0)
            $display("%0t: %0d expected glyph transactions never arrived",
                     $time, expected_glyphs.size());
        if (errors == 0 && expected_glyphs.size() == 0) begin
            $display("markup_text_glyph_placer_unit verification clean");
        end else begin
            $display("markup_text_glyph_placer_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mtgp_pkg.sv
src/markup_text_glyph_placer_unit.sv
tb/tb_markup_text_glyph_placer_unit.sv
